[sv/ubx_frame_parser_macros.svh]
// assertion macros used by the checker file
`ifndef UBX_FRAME_PARSER_MACROS_SVH
`define UBX_FRAME_PARSER_MACROS_SVH

// property checked outside reset
`define UBX_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that also holds across reset
`define UBX_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/ubx_pkg.sv]
package ubx_pkg;

  localparam int TABLE_ENTRIES = 4;
  // entries that have a config register of their own
  localparam int NUM_ENTRY_REGS = 4;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int LEN_W = 16;

  localparam logic [7:0] SYNC_FIRST_RST = 8'hB5;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h62;
  localparam logic [LEN_W-1:0] HEADER_LEN = 16'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_FIRST,
    REG_SYNC_SECOND,
    REG_ENTRY_COUNT,
    REG_ENTRY0,
    REG_ENTRY1,
    REG_ENTRY2,
    REG_ENTRY3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_HEADER,
    PH_PAYLOAD,
    PH_SKIP,
    PH_CKA,
    PH_CKB
  } phase_t;

  typedef enum logic [1:0] {
    EV_PAYLOAD,
    EV_GOOD,
    EV_BAD_SUM,
    EV_UNKNOWN
  } event_t;

  typedef logic [TABLE_ENTRIES-1:0][31:0] tbl_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [2:0] entry_count;
  } cfg_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] index;
    logic [LEN_W-1:0] hit_len;
    logic [LEN_W-1:0] live_len;
  } match_t;

  // entry field carries the index masked to two bits
  function automatic logic [1:0] entry_code(logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[1:0];
  endfunction

endpackage

[sv/ubx_cfg_regs.sv]
module ubx_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ubx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ubx_pkg::CFG_DATA_W-1:0] cfg_data,
  output ubx_pkg::cfg_t                  cfg,
  output ubx_pkg::tbl_t                  tbl
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first <= ubx_pkg::SYNC_FIRST_RST;
      cfg.sync_second <= ubx_pkg::SYNC_SECOND_RST;
      cfg.entry_count <= '0;
      tbl <= '0;
    end else if (cfg_we) begin
      case (ubx_pkg::cfg_reg_t'(cfg_index))
        ubx_pkg::REG_SYNC_FIRST: cfg.sync_first <= cfg_data[7:0];
        ubx_pkg::REG_SYNC_SECOND: cfg.sync_second <= cfg_data[7:0];
        ubx_pkg::REG_ENTRY_COUNT: cfg.entry_count <= cfg_data[2:0];
        default: ;
      endcase
      // entries past the register list stay zero
      for (int i = 0; i < ubx_pkg::TABLE_ENTRIES; i++) begin
        if (i < ubx_pkg::NUM_ENTRY_REGS &&
            cfg_index == ubx_pkg::CFG_IDX_W'(int'(ubx_pkg::REG_ENTRY0) + i)) begin
          tbl[i] <= cfg_data;
        end
      end
    end
  end

endmodule

[sv/ubx_match.sv]
module ubx_match (
  input  ubx_pkg::tbl_t                   tbl,
  input  logic [2:0]                      entry_count,
  input  logic [7:0]                      msg_class,
  input  logic [7:0]                      msg_id,
  input  logic [ubx_pkg::IDX_W-1:0]       cur_index,
  output ubx_pkg::match_t                 m
);

  always_comb begin
    m.hit = 1'b0;
    m.index = '0;
    m.hit_len = '0;
    // walk down so the lowest matching entry wins
    for (int i = ubx_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (i < int'(entry_count) && tbl[i][31:24] == msg_class && tbl[i][23:16] == msg_id) begin
        m.hit = 1'b1;
        m.index = ubx_pkg::IDX_W'(i);
        m.hit_len = tbl[i][15:0];
      end
    end
    m.live_len = '0;
    for (int i = 0; i < ubx_pkg::TABLE_ENTRIES; i++) begin
      if (cur_index == ubx_pkg::IDX_W'(i)) begin
        m.live_len = tbl[i][15:0];
      end
    end
  end

endmodule

[sv/ubx_parse.sv]
module ubx_parse (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      byte_valid,
  output logic                      byte_stall,
  input  logic [7:0]                rx_byte,
  output logic                      event_valid,
  input  logic                      event_stall,
  output logic [1:0]                event_res,
  output logic [1:0]                entry,
  output logic [15:0]               offset,
  output logic [7:0]                payload_data,
  input  ubx_pkg::cfg_t             cfg,
  input  ubx_pkg::match_t           m,
  output logic [7:0]                msg_class,
  output logic [7:0]                msg_id,
  output logic [ubx_pkg::IDX_W-1:0] cur_index
);

  logic                      in_full;
  logic [7:0]                in_byte;
  logic                      advance;
  logic                      work;

  ubx_pkg::phase_t           phase, phase_next;
  logic [15:0]               byte_count, byte_count_next;
  logic [7:0]                sum_a, sum_a_next;
  logic [7:0]                sum_b, sum_b_next;
  logic [7:0]                received_sum_a, received_sum_a_next;
  logic [31:0]               header_bytes, header_bytes_next;
  logic                      matched, matched_next;
  logic [ubx_pkg::IDX_W-1:0] match_index, match_index_next;

  logic                      res_valid;
  ubx_pkg::event_t           res_event;
  logic [1:0]                res_entry;
  logic [15:0]               res_offset;
  logic [7:0]                res_data;

  logic [7:0]                add_a;
  logic [7:0]                add_b;
  logic [15:0]               count_inc;
  logic [31:0]               header_or;

  // result register drains or is empty
  assign advance = !event_valid || !event_stall;
  assign byte_stall = in_full && !advance;
  assign work = in_full && advance;

  assign msg_class = header_bytes[7:0];
  assign msg_id = header_bytes[15:8];
  assign cur_index = match_index;

  assign add_a = sum_a + in_byte;
  assign add_b = sum_b + add_a;
  assign count_inc = byte_count + 16'd1;
  assign header_or = header_bytes | (32'(in_byte) << {byte_count[1:0], 3'b000});

  always_comb begin
    phase_next = phase;
    byte_count_next = byte_count;
    sum_a_next = sum_a;
    sum_b_next = sum_b;
    received_sum_a_next = received_sum_a;
    header_bytes_next = header_bytes;
    matched_next = matched;
    match_index_next = match_index;
    res_valid = 1'b0;
    res_event = ubx_pkg::EV_PAYLOAD;
    res_entry = ubx_pkg::entry_code(match_index);
    res_offset = byte_count;
    res_data = in_byte;
    case (phase)
      ubx_pkg::PH_SYNC2: begin
        if (in_byte == cfg.sync_second) begin
          sum_a_next = '0;
          sum_b_next = '0;
          byte_count_next = '0;
          header_bytes_next = '0;
          matched_next = 1'b0;
          match_index_next = '0;
          phase_next = ubx_pkg::PH_HEADER;
        end else begin
          phase_next = ubx_pkg::PH_SYNC1;
        end
      end
      ubx_pkg::PH_HEADER: begin
        header_bytes_next = header_or;
        sum_a_next = add_a;
        sum_b_next = add_b;
        byte_count_next = count_inc;
        if (count_inc >= ubx_pkg::HEADER_LEN) begin
          byte_count_next = '0;
          matched_next = m.hit;
          match_index_next = m.index;
          if (m.hit) begin
            phase_next = (m.hit_len == '0) ? ubx_pkg::PH_CKA : ubx_pkg::PH_PAYLOAD;
          end else begin
            phase_next = (header_or[31:16] == '0) ? ubx_pkg::PH_CKA : ubx_pkg::PH_SKIP;
          end
        end
      end
      ubx_pkg::PH_PAYLOAD: begin
        sum_a_next = add_a;
        sum_b_next = add_b;
        res_valid = 1'b1;
        byte_count_next = count_inc;
        // length is read live from the matched entry
        if (count_inc == m.live_len) begin
          byte_count_next = '0;
          phase_next = ubx_pkg::PH_CKA;
        end
      end
      ubx_pkg::PH_SKIP: begin
        sum_a_next = add_a;
        sum_b_next = add_b;
        byte_count_next = count_inc;
        if (count_inc == header_bytes[31:16]) begin
          byte_count_next = '0;
          phase_next = ubx_pkg::PH_CKA;
        end
      end
      ubx_pkg::PH_CKA: begin
        received_sum_a_next = in_byte;
        phase_next = ubx_pkg::PH_CKB;
      end
      ubx_pkg::PH_CKB: begin
        res_valid = 1'b1;
        res_offset = '0;
        res_data = '0;
        if (received_sum_a != sum_a || in_byte != sum_b) begin
          res_event = ubx_pkg::EV_BAD_SUM;
        end else if (matched) begin
          res_event = ubx_pkg::EV_GOOD;
        end else begin
          res_event = ubx_pkg::EV_UNKNOWN;
        end
        res_entry = matched ? ubx_pkg::entry_code(match_index) : 2'd0;
        phase_next = ubx_pkg::PH_SYNC1;
        byte_count_next = '0;
        sum_a_next = '0;
        sum_b_next = '0;
        received_sum_a_next = '0;
        header_bytes_next = '0;
        matched_next = 1'b0;
        match_index_next = '0;
      end
      default: begin
        phase_next = (in_byte == cfg.sync_first) ? ubx_pkg::PH_SYNC2 : ubx_pkg::PH_SYNC1;
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_byte <= rx_byte;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ubx_pkg::PH_SYNC1;
      byte_count <= '0;
      sum_a <= '0;
      sum_b <= '0;
      received_sum_a <= '0;
      header_bytes <= '0;
      matched <= 1'b0;
      match_index <= '0;
    end else if (work) begin
      phase <= phase_next;
      byte_count <= byte_count_next;
      sum_a <= sum_a_next;
      sum_b <= sum_b_next;
      received_sum_a <= received_sum_a_next;
      header_bytes <= header_bytes_next;
      matched <= matched_next;
      match_index <= match_index_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (advance) begin
      event_valid <= work && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (work && res_valid) begin
      event_res <= res_event;
      entry <= res_entry;
      offset <= res_offset;
      payload_data <= res_data;
    end
  end

endmodule

[sv/ubx_frame_parser.sv]
// path: a byte accepted into the input register moves on to the result register
//   when that register drains or is empty, and its result transfers from there
// throughput: one byte per cycle; the input register and the result register
//   let a new byte in whenever the result register drains or is empty
// reset: synchronous, active high; sync bytes return to 0xB5/0x62, the table
//   and entry count clear, and the parser waits for the first sync byte
module ubx_frame_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           byte_valid,
  output logic                           byte_stall,
  input  logic [7:0]                     rx_byte,
  output logic                           event_valid,
  input  logic                           event_stall,
  output logic [1:0]                     event_res,
  output logic [1:0]                     entry,
  output logic [15:0]                    offset,
  output logic [7:0]                     payload_data,
  input  logic                           cfg_we,
  input  logic [ubx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ubx_pkg::CFG_DATA_W-1:0] cfg_data
);

  ubx_pkg::cfg_t             cfg;
  ubx_pkg::tbl_t             tbl;
  ubx_pkg::match_t           m;
  logic [7:0]                msg_class;
  logic [7:0]                msg_id;
  logic [ubx_pkg::IDX_W-1:0] cur_index;

  ubx_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .tbl       (tbl)
  );

  ubx_match u_match (
    .tbl         (tbl),
    .entry_count (cfg.entry_count),
    .msg_class   (msg_class),
    .msg_id      (msg_id),
    .cur_index   (cur_index),
    .m           (m)
  );

  ubx_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .rx_byte      (rx_byte),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .event_res    (event_res),
    .entry        (entry),
    .offset       (offset),
    .payload_data (payload_data),
    .cfg          (cfg),
    .m            (m),
    .msg_class    (msg_class),
    .msg_id       (msg_id),
    .cur_index    (cur_index)
  );

endmodule

[sv/ubx_frame_parser_chk.sv]
`include "ubx_frame_parser_macros.svh"

module ubx_frame_parser_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           byte_valid,
  input logic                           byte_stall,
  input logic [7:0]                     rx_byte,
  input logic                           event_valid,
  input logic                           event_stall,
  input logic [1:0]                     event_res,
  input logic [1:0]                     entry,
  input logic [15:0]                    offset,
  input logic [7:0]                     payload_data
);

  `UBX_CHECK_ALWAYS(a_reset_empty, rst |=> !event_valid, "event after reset")

  `UBX_CHECK(a_status_clean, event_valid && event_res != ubx_pkg::EV_PAYLOAD |-> offset == '0 && payload_data == '0, "status event carries payload")

  `UBX_CHECK(a_unknown_entry, event_valid && event_res == ubx_pkg::EV_UNKNOWN |-> entry == '0, "unknown frame with nonzero entry")

  `UBX_CHECK(a_event_hold, event_valid && event_stall |=> event_valid && $stable(event_res) && $stable(offset), "stalled event changed")

  `UBX_CHECK(a_byte_hold, byte_valid && byte_stall |=> byte_valid && $stable(rx_byte), "stalled byte changed")

endmodule

bind ubx_frame_parser ubx_frame_parser_chk u_chk (.*);
